// File: hdl/kts_pkg.sv
// kts_pkg: shared types and constants for the keyword token scanner.
// Used by kts_cell and keyword_token_scanner; no dependencies.
`default_nettype none
package kts_pkg;

    // fixed field widths of the stream words
    localparam int SLOT_W    = 5;
    localparam int POS_W     = 3;
    localparam int LEN_W     = 4;
    localparam int BYTE_W    = 8;
    localparam int GAP_OUT_W = 16;
    localparam int IDX_OUT_W = 5;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 32;

    // command codes (s_tuser)
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // result kinds (m_tuser)
    localparam logic KIND_TOKEN = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // priority chain status handed from cell to cell
    typedef struct packed {
        logic hit;   // an earlier slot matched
        logic stop;  // an earlier slot is empty: list has ended
    } kts_chain_t;

endpackage
`default_nettype wire

// File: hdl/kts_cell.sv
// kts_cell: one pattern slot of the scanner; holds the pattern and its length,
// compares against the lookahead window and joins the priority chain.
// Depends on kts_pkg.
`default_nettype none
module kts_cell
    import kts_pkg::*;
#(
    parameter int CELL_IDX        = 0,
    parameter int IDX_W           = 5,
    parameter int MAX_PATTERN_LEN = 8,
    parameter int FILL_W          = 4
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          wr_en,
    input  wire logic [POS_W-1:0]              wr_pos,
    input  wire logic [LEN_W-1:0]              wr_len,
    input  wire logic [BYTE_W-1:0]             wr_value,
    input  wire logic [MAX_PATTERN_LEN*BYTE_W-1:0] win,
    input  wire logic [FILL_W-1:0]             fill,
    input  wire kts_chain_t                    chain_in,
    input  wire logic [IDX_W-1:0]              idx_in,
    input  wire logic [LEN_W-1:0]              len_in,
    output kts_chain_t                         chain_out,
    output logic [IDX_W-1:0]                   idx_out,
    output logic [LEN_W-1:0]                   len_out
);

    logic [BYTE_W-1:0] pat_reg [MAX_PATTERN_LEN];
    logic [LEN_W-1:0]  len_reg;
    logic              match;

    // length clears on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (wr_en) begin
            len_reg <= wr_len;
        end
    end

    // pattern bytes, undefined until loaded
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            if (wr_en && int'(wr_pos) == i) begin
                pat_reg[i] <= wr_value;
            end
        end
    end

    // compare the window head against the pattern
    always_comb begin
        match = (len_reg != '0) && (int'(len_reg) <= MAX_PATTERN_LEN)
                && (int'(len_reg) <= int'(fill));
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            if (i < int'(len_reg) && pat_reg[i] != win[i*BYTE_W +: BYTE_W]) begin
                match = 1'b0;
            end
        end
    end

    // lowest slot wins; an empty slot ends the list
    always_comb begin
        chain_out = chain_in;
        idx_out   = idx_in;
        len_out   = len_in;
        if (!chain_in.hit && !chain_in.stop) begin
            if (len_reg == '0) begin
                chain_out.stop = 1'b1;
            end else if (match) begin
                chain_out.hit = 1'b1;
                idx_out       = IDX_W'(CELL_IDX);
                len_out       = len_reg;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/keyword_token_scanner.sv
// keyword_token_scanner: top level; lookahead window, gap counter, result
// register and the row of pattern cells. Depends on kts_pkg and kts_cell.
//
//  port group | dir | tdata                              | tuser   | tlast
//  s_         | in  | slot,position,pattern_length,value | command | end_of_buffer
//  m_         | out | gap_length,token_index,token_length| kind    | last_result
//
// A data word enters the window; once the window is full, ST_STEP makes one
// decision before the next word is taken. The final byte of a buffer leads to
// ST_DRAIN: a decision per window position, then the done word. Each decision
// is one pass through the cell chain. Decisions stall while the result register
// is full and m_tready is low. Reset (aresetn, synchronous) clears slot lengths,
// window, counters and the result valid flag.
`default_nettype none
module keyword_token_scanner
    import kts_pkg::*;
#(
    parameter int NUM_PATTERNS    = 32,
    parameter int MAX_PATTERN_LEN = 8,
    parameter int GAP_WIDTH       = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // slot, position, pattern_length, value
    input  wire logic                s_tuser,  // command
    input  wire logic                s_tlast,  // end_of_buffer
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,  // gap_length, token_index, token_length
    output logic                     m_tuser,  // kind
    output logic                     m_tlast   // last_result
);

    localparam int IDX_W  = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int FILL_W = $clog2(MAX_PATTERN_LEN + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_DRAIN
    } state_t;

    state_t                 state_reg;
    logic [BYTE_W-1:0]      win_reg [MAX_PATTERN_LEN];
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      skip_reg;
    logic [GAP_WIDTH-1:0]   gap_reg;
    logic                   m_valid_reg;
    logic                   m_kind_reg;
    logic                   m_last_reg;
    logic [GAP_OUT_W-1:0]   m_gap_reg;
    logic [IDX_OUT_W-1:0]   m_idx_reg;
    logic [LEN_W-1:0]       m_len_reg;

    // input word fields
    logic [SLOT_W-1:0]  in_slot;
    logic [POS_W-1:0]   in_pos;
    logic [LEN_W-1:0]   in_len;
    logic [BYTE_W-1:0]  in_value;

    assign in_slot  = s_tdata[SLOT_W-1:0];
    assign in_pos   = s_tdata[SLOT_W +: POS_W];
    assign in_len   = s_tdata[SLOT_W+POS_W +: LEN_W];
    assign in_value = s_tdata[SLOT_W+POS_W+LEN_W +: BYTE_W];

    logic s_fire, load_fire, data_fire, out_free, step_en;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign load_fire = s_fire && (s_tuser == CMD_LOAD);
    assign data_fire = s_fire && (s_tuser == CMD_DATA);
    assign out_free  = !m_valid_reg || m_tready;
    assign step_en   = out_free && (fill_reg != '0)
                       && (state_reg == ST_STEP || state_reg == ST_DRAIN);

    // flattened window for the cells
    logic [MAX_PATTERN_LEN*BYTE_W-1:0] win_flat;
    always_comb begin
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
            win_flat[i*BYTE_W +: BYTE_W] = win_reg[i];
        end
    end

    // row of pattern cells with the priority chain
    kts_chain_t       chain [NUM_PATTERNS+1];
    logic [IDX_W-1:0] idx_c [NUM_PATTERNS+1];
    logic [LEN_W-1:0] len_c [NUM_PATTERNS+1];

    assign chain[0] = '0;
    assign idx_c[0] = '0;
    assign len_c[0] = '0;

    for (genvar g = 0; g < NUM_PATTERNS; g++) begin : g_cell
        logic wr_en;
        assign wr_en = load_fire && (int'(in_slot) == g);
        kts_cell #(
            .CELL_IDX        (g),
            .IDX_W           (IDX_W),
            .MAX_PATTERN_LEN (MAX_PATTERN_LEN),
            .FILL_W          (FILL_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .wr_en     (wr_en),
            .wr_pos    (in_pos),
            .wr_len    (in_len),
            .wr_value  (in_value),
            .win       (win_flat),
            .fill      (fill_reg),
            .chain_in  (chain[g]),
            .idx_in    (idx_c[g]),
            .len_in    (len_c[g]),
            .chain_out (chain[g+1]),
            .idx_out   (idx_c[g+1]),
            .len_out   (len_c[g+1])
        );
    end

    logic hit;
    assign hit = chain[NUM_PATTERNS].hit;

    // a token or done word is loaded into the result register this cycle
    logic out_load;
    assign out_load = (step_en && skip_reg == '0 && hit)
                      || (state_reg == ST_DRAIN && fill_reg == '0 && out_free);

    // result word valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // control, window and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            skip_reg    <= '0;
            gap_reg     <= '0;
            for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (data_fire) begin
                        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                            if (int'(fill_reg) == i) begin
                                win_reg[i] <= in_value;
                            end
                        end
                        fill_reg <= fill_reg + 1'b1;
                        if (s_tlast) begin
                            state_reg <= ST_DRAIN;
                        end else if (int'(fill_reg) + 1 >= MAX_PATTERN_LEN) begin
                            state_reg <= ST_STEP;
                        end
                    end
                end
                ST_STEP, ST_DRAIN: begin
                    if (step_en) begin
                        // decide the oldest position, then pop it
                        if (skip_reg != '0) begin
                            skip_reg <= skip_reg - 1'b1;
                        end else if (hit) begin
                            m_kind_reg  <= KIND_TOKEN;
                            m_last_reg  <= (state_reg == ST_STEP);
                            m_gap_reg   <= GAP_OUT_W'(gap_reg);
                            m_idx_reg   <= IDX_OUT_W'(idx_c[NUM_PATTERNS]);
                            m_len_reg   <= len_c[NUM_PATTERNS];
                            gap_reg     <= '0;
                            skip_reg    <= FILL_W'(len_c[NUM_PATTERNS] - 1'b1);
                        end else if (gap_reg != '1) begin
                            gap_reg <= gap_reg + 1'b1;
                        end
                        for (int i = 0; i < MAX_PATTERN_LEN - 1; i++) begin
                            win_reg[i] <= win_reg[i+1];
                        end
                        win_reg[MAX_PATTERN_LEN-1] <= '0;
                        fill_reg <= fill_reg - 1'b1;
                        if (state_reg == ST_STEP) begin
                            state_reg <= ST_IDLE;
                        end
                    end else if (state_reg == ST_DRAIN && fill_reg == '0 && out_free) begin
                        // buffer done word, then clear scan state
                        m_kind_reg  <= KIND_DONE;
                        m_last_reg  <= 1'b1;
                        m_gap_reg   <= GAP_OUT_W'(gap_reg);
                        m_idx_reg   <= '0;
                        m_len_reg   <= '0;
                        gap_reg     <= '0;
                        skip_reg    <= '0;
                        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
                            win_reg[i] <= '0;
                        end
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(M_DATA_W-GAP_OUT_W-IDX_OUT_W-LEN_W){1'b0}},
                       m_len_reg, m_idx_reg, m_gap_reg};

endmodule
`default_nettype wire

// File: sim/testbench.sv
// testbench: self-checking regression for keyword_token_scanner.
// Needs kts_pkg and the keyword_token_scanner RTL; predicts every result word in place.
`default_nettype none
module testbench;
    import kts_pkg::*;

    localparam int SLOTS     = 32;
    localparam int WIN       = 8;
    localparam int GAP_MAX   = 65535;
    localparam int LIMIT     = 1500000;
    localparam int SETTLE    = 40;

    typedef struct {
        logic       cmd;
        logic [4:0] slot;
        logic [2:0] pos;
        logic [3:0] plen;
        logic [7:0] val;
        logic       eob;
        bit         drain;   // sender waits here until all results are in
    } scan_word_t;

    typedef struct {
        logic        kind;
        logic [15:0] gap;
        logic [4:0]  idx;
        logic [3:0]  len;
        logic        last;
    } token_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;  // slot, position, pattern_length, value
    logic s_tuser = 1'b0;               // command
    logic s_tlast = 1'b0;               // end_of_buffer
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;       // gap_length, token_index, token_length
    logic m_tuser;                      // kind
    logic m_tlast;                      // last_result

    keyword_token_scanner uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    scan_word_t  pending_words[$];
    token_word_t expected_tokens[$];
    int errors = 0;
    int words_accepted = 0;
    int cycles = 0;
    logic s_fire = 1'b0;

    // predictor state
    logic [7:0] kw_bytes [SLOTS][WIN];
    logic [3:0] kw_len [SLOTS];
    logic [7:0] window [WIN];
    int fill, skip_left, gap_cnt;

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic report(input string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    // decide the oldest window position and shift it out
    task automatic decide_position();
        int s;
        int n;
        bit hit;
        bit ok;
        token_word_t t;
        if (fill == 0) return;
        if (skip_left > 0) begin
            skip_left--;
        end else begin
            hit = 0;
            for (s = 0; s < SLOTS; s++) begin
                n = kw_len[s];
                if (n == 0) break;
                ok = (n <= WIN) && (n <= fill);
                for (int i = 0; ok && i < n; i++)
                    if (kw_bytes[s][i] != window[i]) ok = 0;
                if (ok) begin
                    hit = 1;
                    break;
                end
            end
            if (hit) begin
                t = '{KIND_TOKEN, gap_cnt[15:0], s[4:0], kw_len[s], 1'b0};
                expected_tokens.push_back(t);
                gap_cnt = 0;
                skip_left = kw_len[s] - 1;
            end else if (gap_cnt < GAP_MAX) begin
                gap_cnt++;
            end
        end
        for (int i = 0; i < WIN - 1; i++) window[i] = window[i + 1];
        window[WIN - 1] = 8'h00;
        fill--;
    endtask

    task automatic predict_word(input scan_word_t w);
        int prior_size;
        token_word_t t;
        prior_size = expected_tokens.size();
        if (w.cmd == CMD_LOAD) begin
            kw_len[w.slot] = w.plen;
            kw_bytes[w.slot][w.pos] = w.val;
            return;
        end
        if (fill >= WIN) decide_position();
        window[fill] = w.val;
        fill++;
        if (!w.eob) begin
            if (fill >= WIN) decide_position();
        end else begin
            while (fill > 0) decide_position();
            t = '{KIND_DONE, gap_cnt[15:0], 5'd0, 4'd0, 1'b0};
            expected_tokens.push_back(t);
            for (int i = 0; i < WIN; i++) window[i] = 8'h00;
            skip_left = 0;
            gap_cnt = 0;
        end
        if (expected_tokens.size() > prior_size) expected_tokens[$].last = 1'b1;
    endtask

    // monitor: check results, then predict for the accepted word
    always @(posedge aclk) begin
        token_word_t e;
        scan_word_t w;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                report($sformatf("unexpected word tdata=%h kind=%b", m_tdata, m_tuser));
            end else begin
                e = expected_tokens.pop_front();
                if (m_tuser !== e.kind || m_tdata[15:0] !== e.gap ||
                    m_tdata[20:16] !== e.idx || m_tdata[24:21] !== e.len ||
                    m_tdata[31:25] !== 7'd0 || m_tlast !== e.last)
                    report($sformatf(
                        "got kind=%b gap=%0d idx=%0d len=%0d last=%b, want %b %0d %0d %0d %b",
                        m_tuser, m_tdata[15:0], m_tdata[20:16], m_tdata[24:21], m_tlast,
                        e.kind, e.gap, e.idx, e.len, e.last));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            w.cmd = s_tuser;
            w.slot = s_tdata[4:0];
            w.pos = s_tdata[7:5];
            w.plen = s_tdata[11:8];
            w.val = s_tdata[19:12];
            w.eob = s_tlast;
            w.drain = 0;
            predict_word(w);
            words_accepted++;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // sender
    int  s_gap = 0;
    bit  drain_wait = 0;
    bit  s_calm = 0;
    always @(negedge aclk) begin
        scan_word_t w;
        if (cycles % 128 == 0) s_calm = ($urandom_range(0, 3) == 0);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_fire) begin
            // hold the offered word
        end else if (s_gap > 0) begin
            s_gap--;
            s_tvalid <= 1'b0;
        end else if (drain_wait) begin
            if (expected_tokens.size() == 0) drain_wait = 0;
            s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            if (w.drain) begin
                drain_wait = 1;
                s_tvalid <= 1'b0;
            end else begin
                s_tdata <= {4'd0, w.val, w.plen, w.pos, w.slot};
                s_tuser <= w.cmd;
                s_tlast <= w.eob;
                s_tvalid <= 1'b1;
                s_gap = s_calm ? 0 : pick_gap();
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // receiver, with one long hold-off once traffic is flowing
    int  hold_left = 0;
    bit  held_once = 0;
    bit  m_calm = 0;
    int  m_gap = 0;
    always @(negedge aclk) begin
        if (cycles % 96 == 0) m_calm = ($urandom_range(0, 3) == 0);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!held_once && words_accepted > 310) begin
            held_once = 1;
            hold_left = 300;
            m_tready <= 1'b0;
        end else if (m_gap > 0) begin
            m_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            m_gap = m_calm ? 0 : pick_gap();
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("keyword_token_scanner regression: fail");
            $finish;
        end
    end

    task automatic add_load(input int slot, input int pos, input int plen, input int val);
        scan_word_t w;
        w = '{CMD_LOAD, slot[4:0], pos[2:0], plen[3:0], val[7:0], 1'b0, 1'b0};
        pending_words.push_back(w);
    endtask

    task automatic add_byte(input int val, input bit eob);
        scan_word_t w;
        w = '{CMD_DATA, 5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
              4'($urandom_range(0, 15)), val[7:0], eob, 1'b0};
        pending_words.push_back(w);
    endtask

    task automatic add_drain();
        scan_word_t w;
        w = '{CMD_LOAD, 5'd0, 3'd0, 4'd0, 8'd0, 1'b0, 1'b1};
        pending_words.push_back(w);
    endtask

    task automatic add_text(input string txt);
        for (int i = 0; i < txt.len(); i++) add_byte(txt[i], i == txt.len() - 1);
    endtask

    function automatic int letter();
        return "a" + $urandom_range(0, 2);
    endfunction

    // stimulus
    initial begin
        int n, blen;
        string kw8;
        for (int s = 0; s < SLOTS; s++) begin
            kw_len[s] = 4'd0;
            for (int i = 0; i < WIN; i++) kw_bytes[s][i] = 8'h00;
        end
        for (int i = 0; i < WIN; i++) window[i] = 8'h00;
        fill = 0;
        skip_left = 0;
        gap_cnt = 0;
        kw8 = "abcdefgh";

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // every slot gets all eight bytes written; mostly short patterns
        for (int s = 0; s < SLOTS; s++) begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 8) : $urandom_range(2, 3);
            for (int i = 0; i < WIN; i++) add_load(s, i, n, letter());
        end
        // directed: single byte token, full-length token at buffer end,
        // overlong and empty slots, extreme byte values
        add_load(0, 0, 1, "z");
        add_load(1, 0, 15, "a");
        for (int i = 0; i < WIN; i++) add_load(2, i, 8, kw8[i]);
        add_text("z");
        add_text("qabcdefgh");
        add_text("abcdefg");
        add_byte(8'h00, 0);
        add_byte(8'hFF, 1);
        add_load(4, 0, 0, "b");
        add_text("cbazzab");
        add_load(4, 0, 2, "b");
        add_drain();

        // random buffers with pattern-rich content
        n = 0;
        while (n < 100) begin
            blen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 14);
            for (int i = 0; i < blen; i++) begin
                if ($urandom_range(0, 19) == 0)
                    add_load($urandom_range(1, 31), $urandom_range(0, 7),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(1, 4),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : letter());
                add_byte(($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : letter(),
                         i == blen - 1);
                n++;
            end
            if ($urandom_range(0, 15) == 0) add_drain();
        end

        // short tail after a full drain
        add_drain();
        add_load(0, 0, 1, "a");
        add_text("xxaab");

        while (!(pending_words.size() == 0 && !drain_wait && (!s_tvalid || s_fire)))
            @(negedge aclk);
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (expected_tokens.size() != 0) report("results left over at the end");
        if (errors == 0) begin
            $display("keyword_token_scanner regression: pass");
        end else begin
            $display("keyword_token_scanner regression: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
